// File: rtl/bpp_pkg.sv
package bpp_pkg;

  localparam int unsigned DEFAULT_COLUMNS = 1024;
  localparam int unsigned DEFAULT_ROWS    = 768;

  localparam int unsigned PIX_W  = 20;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_SINGLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MEDIUM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LARGE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NEG   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // microcode layout: single step, medium program, large program
  localparam int unsigned UC_DEPTH = 37;
  localparam int unsigned PC_W     = $clog2(UC_DEPTH);

  localparam logic [PC_W-1:0] ENTRY_SINGLE = PC_W'(0);
  localparam logic [PC_W-1:0] ENTRY_MEDIUM = PC_W'(1);
  localparam logic [PC_W-1:0] ENTRY_LARGE  = PC_W'(8);

  typedef struct packed {
    logic              single;
    logic              last;
    logic signed [3:0] dx;
    logic signed [3:0] dy;
  } ucode_t;

  typedef struct packed {
    ucode_t cw;
    logic   minus;
  } agen_ctl_t;

  typedef struct packed {
    logic             in_range;
    logic [PIX_W-1:0] addr;
  } agen_res_t;

  function automatic ucode_t uc(input int dx, input int dy);
    ucode_t w;
    w.single = 1'b0;
    w.last   = (dx == 0) && (dy == 0);
    w.dx     = 4'(dx);
    w.dy     = 4'(dy);
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] idx);
    ucode_t w;
    case (idx)
      6'd1:  w = uc( 0, -2);
      6'd2:  w = uc(-1, -1);
      6'd3:  w = uc( 0, -1);
      6'd4:  w = uc( 1, -1);
      6'd5:  w = uc(-2,  0);
      6'd6:  w = uc(-1,  0);
      6'd7:  w = uc( 0,  0);
      6'd8:  w = uc(-1, -4);
      6'd9:  w = uc( 0, -4);
      6'd10: w = uc( 1, -4);
      6'd11: w = uc(-2, -3);
      6'd12: w = uc(-1, -3);
      6'd13: w = uc( 0, -3);
      6'd14: w = uc( 1, -3);
      6'd15: w = uc( 2, -3);
      6'd16: w = uc(-3, -2);
      6'd17: w = uc(-2, -2);
      6'd18: w = uc(-1, -2);
      6'd19: w = uc( 0, -2);
      6'd20: w = uc( 1, -2);
      6'd21: w = uc( 2, -2);
      6'd22: w = uc( 3, -2);
      6'd23: w = uc(-4, -1);
      6'd24: w = uc(-3, -1);
      6'd25: w = uc(-2, -1);
      6'd26: w = uc(-1, -1);
      6'd27: w = uc( 0, -1);
      6'd28: w = uc( 1, -1);
      6'd29: w = uc( 2, -1);
      6'd30: w = uc( 3, -1);
      6'd31: w = uc( 4, -1);
      6'd32: w = uc(-4,  0);
      6'd33: w = uc(-3,  0);
      6'd34: w = uc(-2,  0);
      6'd35: w = uc(-1,  0);
      6'd36: w = uc( 0,  0);
      default: begin
        w        = uc(0, 0);
        w.single = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_of(input logic [FUNC_W-1:0] f);
    logic [PC_W-1:0] e;
    case (f)
      FUNC_MEDIUM: e = ENTRY_MEDIUM;
      FUNC_LARGE:  e = ENTRY_LARGE;
      default:     e = ENTRY_SINGLE;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/brush_point_plotter_unit.sv
// Brush point plotter. Each request on the slave side carries a signed
// centre (x, y), an RGB color and a brush code (single, medium, large);
// the master side returns pixel writes for every brush pixel that lands
// on the screen, in table order (plus offset, then minus offset), with
// tlast on the final write. Offsets are applied to the linear index, so
// brushes wrap across row ends. A negative coordinate or a centre past the
// screen yields one status-only item. The request is taken in S_IDLE, the
// centre multiply is registered in S_MUL and the checks run in S_CHECK;
// then S_RUN walks every candidate address of the brush program, skipped
// or not, as the address unit and the output register handle one candidate
// per cycle while the output register is free; an output stall holds the
// walk. A new request is taken only once the unit is back in S_IDLE.
module brush_point_plotter_unit #(
  parameter int unsigned SCREEN_COLUMNS = bpp_pkg::DEFAULT_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = bpp_pkg::DEFAULT_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [55:0] s_tdata_i,  // x_coord, y_coord, red_in, green_in, blue_in
  input  logic [1:0]  s_tuser_i,  // func
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,  // pixel_address, red_out, green_out, blue_out, pad
  output logic [2:0]  m_tuser_o,  // write_valid, status
  output logic        m_tlast_o
);
  import bpp_pkg::*;

  localparam int unsigned CENW = 16 + $clog2(SCREEN_COLUMNS);
  localparam logic [CENW:0] SIZE_U = (CENW + 1)'(SCREEN_COLUMNS * SCREEN_ROWS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic              minus_q, minus_d;

  logic [FUNC_W-1:0] func_q;
  logic [15:0]       x_q, y_q;
  logic [COL_W-1:0]  r_q, g_q, b_q;
  logic [CENW-1:0]   centre_q;
  logic [CENW-1:0]   centre_d;

  logic              out_valid_q, out_valid_d;
  logic              out_last_q, out_last_d;
  logic              out_wv_q, out_wv_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;
  logic [PIX_W-1:0]  out_addr_q, out_addr_d;
  logic [COL_W-1:0]  out_r_q, out_r_d, out_g_q, out_g_d, out_b_q, out_b_d;

  logic              s_fire;
  logic              out_free;
  logic              out_load;
  ucode_t            cw;
  agen_ctl_t         actl;
  agen_res_t         ares;

  assign s_tready_o = (state_q == S_IDLE);
  assign s_fire     = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;
  assign cw         = ucode_rom(pc_q);
  assign actl.cw    = cw;
  assign actl.minus = minus_q;
  assign centre_d   = CENW'(x_q[14:0]) + CENW'(y_q[14:0]) * CENW'(SCREEN_COLUMNS);

  bpp_agen #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS),
    .CENW          (CENW)
  ) u_agen (
    .centre_i(centre_q),
    .ctl_i   (actl),
    .res_o   (ares)
  );

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    minus_d    = minus_q;
    out_load   = 1'b0;
    out_last_d = 1'b0;
    out_wv_d   = 1'b0;
    out_stat_d = STAT_OK;
    out_addr_d = '0;
    out_r_d    = '0;
    out_g_d    = '0;
    out_b_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (s_fire) state_d = S_MUL;
      end
      S_MUL: state_d = S_CHECK;
      S_CHECK: begin
        if (out_free) begin
          if (x_q[15] || y_q[15]) begin
            out_load   = 1'b1;
            out_last_d = 1'b1;
            out_stat_d = STAT_NEG;
            state_d    = S_IDLE;
          end else if ({1'b0, centre_q} >= SIZE_U) begin
            out_load   = 1'b1;
            out_last_d = 1'b1;
            out_stat_d = STAT_RANGE;
            state_d    = S_IDLE;
          end else begin
            pc_d    = entry_of(func_q);
            minus_d = 1'b0;
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (out_free) begin
          if (ares.in_range) begin
            out_load   = 1'b1;
            out_wv_d   = 1'b1;
            out_last_d = cw.last && (cw.single || minus_q);
            out_addr_d = ares.addr;
            out_r_d    = r_q;
            out_g_d    = g_q;
            out_b_d    = b_q;
          end
          if (cw.single || minus_q) begin
            minus_d = 1'b0;
            if (cw.last) state_d = S_IDLE;
            else         pc_d    = pc_q + 1'b1;
          end else begin
            minus_d = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load)        out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
    else                 out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      minus_q     <= minus_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      func_q <= s_tuser_i;
      x_q    <= s_tdata_i[15:0];
      y_q    <= s_tdata_i[31:16];
      r_q    <= s_tdata_i[39:32];
      g_q    <= s_tdata_i[47:40];
      b_q    <= s_tdata_i[55:48];
    end
    if (state_q == S_MUL) centre_q <= centre_d;
    if (out_load) begin
      out_last_q <= out_last_d;
      out_wv_q   <= out_wv_d;
      out_stat_q <= out_stat_d;
      out_addr_q <= out_addr_d;
      out_r_q    <= out_r_d;
      out_g_q    <= out_g_d;
      out_b_q    <= out_b_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000, out_b_q, out_g_q, out_r_q, out_addr_q};
  assign m_tuser_o  = {out_stat_q, out_wv_q};
  assign m_tlast_o  = out_last_q;

  a_status_only_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o[0]) |-> (m_tlast_o && (m_tuser_o[2:1] != STAT_OK)))
    else $error("status-only item without error code or tlast");

  a_write_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[0]) |-> (m_tuser_o[2:1] == STAT_OK))
    else $error("pixel write with nonzero status");

  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == S_MUL))
    else $error("accepted request did not start the centre multiply");

  a_pc_in_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (pc_q < PC_W'(UC_DEPTH)))
    else $error("microcode step counter beyond the program");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_tready_i) |=> $stable(out_addr_q))
    else $error("output register overwritten while stalled");

endmodule

// File: rtl/bpp_agen.sv
module bpp_agen #(
  parameter int unsigned SCREEN_COLUMNS = bpp_pkg::DEFAULT_COLUMNS,
  parameter int unsigned SCREEN_ROWS    = bpp_pkg::DEFAULT_ROWS,
  parameter int unsigned CENW           = 16 + $clog2(SCREEN_COLUMNS)
) (
  input  logic [CENW-1:0]       centre_i,
  input  bpp_pkg::agen_ctl_t    ctl_i,
  output bpp_pkg::agen_res_t    res_o
);
  import bpp_pkg::*;

  localparam int unsigned OW = $clog2(SCREEN_COLUMNS) + 5;
  localparam int unsigned AW = CENW + 2;
  localparam logic signed [OW-1:0] COLS_S = OW'(SCREEN_COLUMNS);
  localparam logic signed [AW-1:0] SIZE_S = AW'(SCREEN_COLUMNS * SCREEN_ROWS);

  logic signed [OW-1:0] dx_w;
  logic signed [OW-1:0] dy_w;
  logic signed [OW-1:0] off;
  logic signed [AW-1:0] c_s;
  logic signed [AW-1:0] off_e;
  logic signed [AW-1:0] cand;

  assign dx_w  = OW'(ctl_i.cw.dx);
  assign dy_w  = OW'(ctl_i.cw.dy);
  assign off   = dx_w + dy_w * COLS_S;
  assign c_s   = $signed({2'b00, centre_i});
  assign off_e = AW'(off);
  assign cand  = ctl_i.minus ? (c_s - off_e) : (c_s + off_e);

  assign res_o.in_range = !cand[AW-1] && (cand < SIZE_S);
  assign res_o.addr     = cand[PIX_W-1:0];

endmodule
